### rtl/core/pcsm_pkg.sv
`timescale 1ns / 1ps

package pcsm_pkg;

    localparam int SLOTS     = 8;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FIXED_MAX = 3;
    localparam int HW_W      = 3;
    localparam int GEN_MAX   = 1 << HW_W;
    localparam int CNT_W     = 64;
    localparam int TASK_W    = 32;
    localparam int EV_W      = 16;
    localparam int CWID_W    = 7;
    localparam int CFG_W     = 7;

    localparam logic [EV_W-1:0] EV_CYCLES = 16'h003C;
    localparam logic [EV_W-1:0] EV_INSNS  = 16'h00C0;
    localparam logic [EV_W-1:0] EV_REFCYC = 16'h013C;

    typedef enum logic [1:0] {
        MODE_ALLOC,
        MODE_FREE,
        MODE_QUERY,
        MODE_ACCUM
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_UNSUP,
        STAT_BUSY
    } t_status;

    typedef enum logic [1:0] {
        CFG_PMU,
        CFG_GEN,
        CFG_FIX,
        CFG_WIDTH
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_ALLOC,
        S_ACC_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic scan_step;
        logic alloc;
        logic acc_add;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  pmu;
        logic  changed;
        logic  scan_last;
    } t_dp_stat;

    // {hit, fixed counter index}
    function automatic logic [2:0] fixed_for(input logic [EV_W-1:0] ev);
        logic [2:0] res;
        res = 3'b000;
        if (ev == EV_INSNS) begin
            res = 3'b100;
        end else if (ev == EV_CYCLES) begin
            res = 3'b101;
        end else if (ev == EV_REFCYC) begin
            res = 3'b110;
        end
        return res;
    endfunction

endpackage

### rtl/core/pcsm_ctrl.sv
`timescale 1ns / 1ps

module pcsm_ctrl
    import pcsm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.mode)
                    MODE_ALLOC: n_state = i_stat.pmu ? S_SCAN : S_DONE;
                    MODE_FREE:  n_state = S_DONE;
                    MODE_QUERY: n_state = S_DONE;
                    MODE_ACCUM: begin
                        n_state = (i_stat.pmu && !i_stat.changed) ? S_ACC_ADD : S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC:   n_state = S_DONE;
            S_ACC_ADD: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.alloc     = (r_state == S_ALLOC);
        o_cmd.acc_add   = (r_state == S_ACC_ADD);
        o_cmd.out_load  = (r_state == S_DONE) && out_free;
        o_in_stall      = (r_state != S_IDLE);
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/pcsm_datapath.sv
`timescale 1ns / 1ps

module pcsm_datapath
    import pcsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_mode,
    input  logic [EV_W-1:0]   i_event_select,
    input  logic [TASK_W-1:0] i_target_task,
    input  logic [2:0]        i_slot_index,
    input  logic [CNT_W-1:0]  i_counter_reading,
    input  logic [TASK_W-1:0] i_running_task,
    output logic [1:0]        o_status,
    output logic [2:0]        o_granted_slot,
    output logic [HW_W-1:0]   o_hw_counter,
    output logic              o_uses_fixed,
    output logic [CNT_W-1:0]  o_count_value,
    output logic              o_reprogram
);

    logic              r_pmu;
    logic [3:0]        r_gen;
    logic [1:0]        r_fix;
    logic [CWID_W-1:0] r_width;

    t_mode             r_mode;
    logic [EV_W-1:0]   r_ev;
    logic [TASK_W-1:0] r_target;
    logic [2:0]        r_idx;
    logic [CNT_W-1:0]  r_reading;
    logic [TASK_W-1:0] r_running;

    logic [SLOTS-1:0]  r_busy;
    logic [SLOTS-1:0]  r_live;
    logic              r_changed;
    logic [CNT_W-1:0]  r_prior   [SLOTS];
    logic [TASK_W-1:0] r_task    [SLOTS];
    logic [SLOTS-1:0]  r_is_fixed;
    logic [HW_W-1:0]   r_counter [SLOTS];
    logic [CNT_W-1:0]  r_total   [SLOTS];

    logic [SLOT_W-1:0] r_scan;
    logic [GEN_MAX-1:0] r_fix_taken;
    logic [GEN_MAX-1:0] r_gen_taken;
    logic              r_free_found;
    logic [SLOT_W-1:0] r_free_slot;

    logic [CNT_W-1:0]  r_delta;
    logic              r_credit;

    t_status           r_res_status;
    logic [2:0]        r_res_slot;
    logic [HW_W-1:0]   r_res_hw;
    logic              r_res_fixed;
    logic [CNT_W-1:0]  r_res_count;
    logic              r_res_reprog;

    t_status           r_out_status;
    logic [2:0]        r_out_slot;
    logic [HW_W-1:0]   r_out_hw;
    logic              r_out_fixed;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_reprog;

    logic              idx_ok;
    logic [SLOT_W-1:0] idx_sel;
    logic [CNT_W-1:0]  mask;
    logic [CNT_W-1:0]  now_val;
    logic [CNT_W-1:0]  delta_c;
    logic              task_hit;
    logic              acc_ok;
    logic [2:0]        fx_code;
    logic              fx_ok;
    logic [1:0]        nfix;
    logic [3:0]        ngen;
    logic              gen_found;
    logic [HW_W-1:0]   gen_hw;
    logic [HW_W-1:0]   hw_sel;
    logic              grant;

    assign idx_ok  = (32'(r_idx) < 32'(SLOTS));
    assign idx_sel = SLOT_W'(r_idx);

    always_comb begin
        for (int b = 0; b < CNT_W; b++) begin
            mask[b] = (CWID_W'(b) < r_width);
        end
    end

    assign now_val  = r_reading & mask;
    assign delta_c  = (now_val - r_prior[idx_sel]) & mask;
    assign task_hit = (r_task[idx_sel] == '0) || (r_task[idx_sel] == r_running);
    assign acc_ok   = idx_ok && r_live[idx_sel] && r_busy[idx_sel];

    assign fx_code = fixed_for(r_ev);
    assign nfix    = (32'(r_fix) > FIXED_MAX) ? 2'(FIXED_MAX) : r_fix;
    assign fx_ok   = fx_code[2] && (fx_code[1:0] < nfix)
                     && !r_fix_taken[HW_W'(fx_code[1:0])];
    assign ngen    = (32'(r_gen) > GEN_MAX) ? 4'(GEN_MAX) : r_gen;

    always_comb begin
        gen_found = 1'b0;
        gen_hw    = '0;
        for (int h = 0; h < GEN_MAX; h++) begin
            if (!gen_found && (4'(h) < ngen) && !r_gen_taken[h]) begin
                gen_found = 1'b1;
                gen_hw    = HW_W'(h);
            end
        end
    end

    assign hw_sel = fx_ok ? HW_W'(fx_code[1:0]) : gen_hw;
    assign grant  = (fx_ok || gen_found) && r_free_found;

    assign o_stat.mode      = r_mode;
    assign o_stat.pmu       = r_pmu;
    assign o_stat.changed   = r_changed;
    assign o_stat.scan_last = (r_scan == SLOT_W'(SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmu   <= 1'b0;
            r_gen   <= 4'd4;
            r_fix   <= 2'd3;
            r_width <= 7'd48;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PMU:   r_pmu   <= i_cfg_data[0];
                CFG_GEN:   r_gen   <= i_cfg_data[3:0];
                CFG_FIX:   r_fix   <= i_cfg_data[1:0];
                CFG_WIDTH: r_width <= i_cfg_data[CWID_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode    <= t_mode'(i_mode);
            r_ev      <= i_event_select;
            r_target  <= i_target_task;
            r_idx     <= i_slot_index;
            r_reading <= i_counter_reading;
            r_running <= i_running_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_live    <= '0;
            r_changed <= 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                r_prior[i] <= '0;
            end
        end else begin
            if (i_cmd.exec) begin
                unique case (r_mode)
                    MODE_FREE: begin
                        if (idx_ok && r_busy[idx_sel]) begin
                            r_busy[idx_sel] <= 1'b0;
                            r_changed       <= 1'b1;
                        end
                    end
                    MODE_ACCUM: begin
                        if (r_pmu) begin
                            if (r_changed) begin
                                r_live    <= r_busy;
                                r_changed <= 1'b0;
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (r_busy[i]) begin
                                        r_prior[i] <= '0;
                                    end
                                end
                            end else if (acc_ok) begin
                                r_prior[idx_sel] <= now_val;
                            end
                        end
                    end
                    MODE_ALLOC, MODE_QUERY: ;
                endcase
            end
            if (i_cmd.alloc && grant) begin
                r_busy[r_free_slot] <= 1'b1;
                r_changed           <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_delta  <= delta_c;
            r_credit <= r_pmu && !r_changed && acc_ok && (delta_c != '0) && task_hit;
        end
        if (i_cmd.alloc && grant) begin
            r_task[r_free_slot]     <= r_target;
            r_is_fixed[r_free_slot] <= fx_ok;
            r_counter[r_free_slot]  <= hw_sel;
            r_total[r_free_slot]    <= '0;
        end
        if (i_cmd.acc_add && r_credit) begin
            r_total[idx_sel] <= r_total[idx_sel] + r_delta;
        end
    end

    // slot walk: collects taken counters and the lowest free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan       <= '0;
            r_fix_taken  <= '0;
            r_gen_taken  <= '0;
            r_free_found <= 1'b0;
            r_free_slot  <= '0;
        end else if (i_cmd.exec) begin
            r_scan       <= '0;
            r_fix_taken  <= '0;
            r_gen_taken  <= '0;
            r_free_found <= 1'b0;
            r_free_slot  <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + 1'b1;
            if (r_busy[r_scan]) begin
                if (r_is_fixed[r_scan]) begin
                    r_fix_taken[r_counter[r_scan]] <= 1'b1;
                end else begin
                    r_gen_taken[r_counter[r_scan]] <= 1'b1;
                end
            end else if (!r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_scan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_status <= STAT_OK;
            r_res_slot   <= '0;
            r_res_hw     <= '0;
            r_res_fixed  <= 1'b0;
            r_res_count  <= '0;
            r_res_reprog <= 1'b0;
        end
        if (i_cmd.exec) begin
            unique case (r_mode)
                MODE_ALLOC: begin
                    if (!r_pmu) begin
                        r_res_status <= STAT_UNSUP;
                    end
                end
                MODE_QUERY: begin
                    r_res_count <= idx_ok ? r_total[idx_sel] : '0;
                end
                MODE_ACCUM: begin
                    if (!r_pmu) begin
                        r_res_status <= STAT_UNSUP;
                    end else if (r_changed) begin
                        r_res_reprog <= 1'b1;
                    end
                end
                MODE_FREE: ;
            endcase
        end
        if (i_cmd.alloc) begin
            if (grant) begin
                r_res_slot  <= 3'(r_free_slot);
                r_res_hw    <= hw_sel;
                r_res_fixed <= fx_ok;
            end else begin
                r_res_status <= STAT_BUSY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_hw     <= r_res_hw;
            r_out_fixed  <= r_res_fixed;
            r_out_count  <= r_res_count;
            r_out_reprog <= r_res_reprog;
        end
    end

    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_slot;
    assign o_hw_counter   = r_out_hw;
    assign o_uses_fixed   = r_out_fixed;
    assign o_count_value  = r_out_count;
    assign o_reprogram    = r_out_reprog;

endmodule

### rtl/core/perf_counter_slot_manager.sv
`timescale 1ns / 1ps

// Slot table for a performance-monitoring unit. One item is taken at a time.
// Free, query, an accumulate that reprograms and any alloc or accumulate
// without a PMU go from the execute step straight to the result. Any
// other accumulate passes through the add step before its result. An alloc
// with a PMU first walks the slot table, one slot per cycle, which finds the
// taken counters and the lowest free slot, and then tries to grant a slot.
// A result is loaded once the output register is free, and the next item
// can be taken in the cycle after the result is loaded.
// A finished result sits in the output register while the next item is
// taken in. A result that is still stalled there holds the next one back.
// Configuration writes go through the plain write port at any time the block
// is idle.

module perf_counter_slot_manager
    import pcsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [EV_W-1:0]   i_event_select,
    input  logic [TASK_W-1:0] i_target_task,
    input  logic              i_count_user,
    input  logic              i_count_kernel,
    input  logic [2:0]        i_slot_index,
    input  logic [CNT_W-1:0]  i_counter_reading,
    input  logic [TASK_W-1:0] i_running_task,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [2:0]        o_granted_slot,
    output logic [HW_W-1:0]   o_hw_counter,
    output logic              o_uses_fixed,
    output logic [CNT_W-1:0]  o_count_value,
    output logic              o_reprogram
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pcsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pcsm_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_mode),
        .i_event_select    (i_event_select),
        .i_target_task     (i_target_task),
        .i_slot_index      (i_slot_index),
        .i_counter_reading (i_counter_reading),
        .i_running_task    (i_running_task),
        .o_status          (o_status),
        .o_granted_slot    (o_granted_slot),
        .o_hw_counter      (o_hw_counter),
        .o_uses_fixed      (o_uses_fixed),
        .o_count_value     (o_count_value),
        .o_reprogram       (o_reprogram)
    );

endmodule

### rtl/core/pcsm_checker.sv
`timescale 1ns / 1ps

module pcsm_checker
    import pcsm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_status,
    input logic [2:0]        o_granted_slot,
    input logic [HW_W-1:0]   o_hw_counter,
    input logic              o_uses_fixed,
    input logic [CNT_W-1:0]  o_count_value,
    input logic              o_reprogram
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_count_value)
            && $stable(o_status) && $stable(o_granted_slot))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer taken while busy");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STAT_OK |-> !o_uses_fixed
            && o_granted_slot == '0 && o_hw_counter == '0 && !o_reprogram)
        else $error("failed item carries a grant");

    a_reprog_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reprogram |-> o_status == STAT_OK && o_count_value == '0)
        else $error("reprogram with bad status or count");

    a_fixed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_uses_fixed |-> o_hw_counter < HW_W'(FIXED_MAX))
        else $error("fixed counter index out of range");

endmodule

bind perf_counter_slot_manager pcsm_checker u_pcsm_checker (.*);
